// File: hw/rtl/ptb_pkg.sv
package ptb_pkg;

  localparam int CMD_W = 3;
  localparam int ID_W = 3;
  localparam int TIME_W = 32;
  localparam int MAX_IDS = 1 << ID_W;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd5;

  localparam logic [TIME_W-1:0] GUARD_TICKS = 32'd2;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
    logic result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_start;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: hw/rtl/ptb_in_if.sv
interface ptb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptb_pkg::CMD_W-1:0]     command;
  logic [ptb_pkg::ID_W-1:0]      timer_id;
  logic [ptb_pkg::TIME_W-1:0]    delay_ms;

  modport source (output valid, output command, output timer_id, output delay_ms,
                  input ready);
  modport sink (input valid, input command, input timer_id, input delay_ms,
                output ready);
endinterface

// File: hw/rtl/ptb_out_if.sv
interface ptb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          expired;
  logic [ptb_pkg::TIME_W-1:0]    remaining_ticks;

  modport source (output valid, output expired, output remaining_ticks, input ready);
  modport sink (input valid, input expired, input remaining_ticks, output ready);
endinterface

// File: hw/rtl/pausable_timer_bank_core.sv
// Each accepted item passes through the controller's load, execute and result
// steps before out_valid rises; start also goes through the divider state, a
// reciprocal multiply that scales the delay. No new item is taken until the
// result step, which waits while an unread result is held, frees the input side.
// Reset (rst_n, synchronous, active low): time 0, all timers stopped with
// deadline 0, run timer id 0, no result pending.
module pausable_timer_bank_core #(
  parameter int NUM_TIMERS     = 8,
  parameter int TICK_PERIOD_MS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ptb_pkg::ID_W-1:0]  cfg_wdata,
  ptb_in_if.sink                    in_ch,
  ptb_out_if.source                 out_ch
);

  ptb_pkg::ctrl_cmd_t cmd;
  ptb_pkg::ctrl_sts_t sts;
  logic               in_ready;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptb_dp #(
    .NUM_TIMERS     (NUM_TIMERS),
    .TICK_PERIOD_MS (TICK_PERIOD_MS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_ch.command),
    .in_timer_id         (in_ch.timer_id),
    .in_delay_ms         (in_ch.delay_ms),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_expired         (out_ch.expired),
    .out_remaining_ticks (out_ch.remaining_ticks),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  assign in_ch.ready = in_ready;

endmodule

// File: hw/rtl/ptb_ctrl.sv
module ptb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptb_pkg::ctrl_sts_t  sts,
  output ptb_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DIV    = 2'd1,
    S_EXEC   = 2'd2,
    S_RESULT = 2'd3
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_is_start ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: hw/rtl/ptb_dp.sv
module ptb_dp #(
  parameter int NUM_TIMERS     = 8,
  parameter int TICK_PERIOD_MS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptb_pkg::ID_W-1:0]      cfg_wdata,
  input  logic [ptb_pkg::CMD_W-1:0]     in_command,
  input  logic [ptb_pkg::ID_W-1:0]      in_timer_id,
  input  logic [ptb_pkg::TIME_W-1:0]    in_delay_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_expired,
  output logic [ptb_pkg::TIME_W-1:0]    out_remaining_ticks,
  input  ptb_pkg::ctrl_cmd_t            cmd,
  output ptb_pkg::ctrl_sts_t            sts
);

  localparam int BANK = (NUM_TIMERS < ptb_pkg::MAX_IDS) ? NUM_TIMERS : ptb_pkg::MAX_IDS;
  localparam int IDX_W = (BANK > 1) ? $clog2(BANK) : 1;
  localparam int TW = ptb_pkg::TIME_W;
  localparam int DIV_SH = $clog2(TICK_PERIOD_MS);
  localparam int DIV_SH1 = (DIV_SH > 0) ? 1 : 0;
  localparam int DIV_SH2 = (DIV_SH > 0) ? DIV_SH - 1 : 0;
  localparam logic [2*TW-1:0] DIV_MAGIC_W =
    ((64'd1 << TW) * ((64'd1 << DIV_SH) - 64'(TICK_PERIOD_MS))) / 64'(TICK_PERIOD_MS) + 64'd1;
  localparam logic [TW-1:0] DIV_MAGIC = DIV_MAGIC_W[TW-1:0];

  logic [ptb_pkg::CMD_W-1:0] cmd_r;
  logic [ptb_pkg::ID_W-1:0]  id_r;
  logic [ptb_pkg::ID_W-1:0]  run_id_r;
  logic [TW-1:0]             quo_r;
  logic [TW-1:0]             mul_hi_r;
  logic                      cnt_r;
  logic                      exp_r, exp_nxt;
  logic [TW-1:0]             time_r, time_nxt;
  ptb_pkg::mode_t            mode_r [BANK];
  ptb_pkg::mode_t            mode_nxt [BANK];
  logic [TW-1:0]             dl_r [BANK];
  logic [TW-1:0]             dl_nxt [BANK];

  logic                      out_valid_r;
  logic                      out_expired_r;
  logic [TW-1:0]             out_remaining_r;

  logic [2*TW-1:0]           mul_full;
  logic [TW-1:0]             quo_diff;
  logic [TW-1:0]             quo_fix;
  logic [ptb_pkg::ID_W-1:0]  sel_addr;
  logic                      sel_ok, id_ok;
  ptb_pkg::mode_t            sel_mode;
  logic [TW-1:0]             dl_sel;
  logic [TW-1:0]             time_inc;
  logic [TW-1:0]             remaining;

  // divide by the tick period: reciprocal multiply, then correct and shift
  always_comb begin
    mul_full = (2*TW)'(quo_r) * (2*TW)'(DIV_MAGIC);
    quo_diff = (quo_r - mul_hi_r) >> DIV_SH1;
    quo_fix  = (mul_hi_r + quo_diff) >> DIV_SH2;
  end

  always_comb begin
    sel_addr = (cmd.exec && cmd_r == ptb_pkg::CMD_TICK) ? run_id_r : id_r;
    sel_ok   = 32'(sel_addr) < NUM_TIMERS;
    id_ok    = 32'(id_r) < NUM_TIMERS;
    sel_mode = sel_ok ? mode_r[sel_addr[IDX_W-1:0]] : ptb_pkg::MODE_STOPPED;
    dl_sel   = dl_r[id_r[IDX_W-1:0]];
    time_inc = time_r + 1'b1;
  end

  always_comb begin
    time_nxt = time_r;
    exp_nxt  = exp_r;
    for (int i = 0; i < BANK; i++) begin
      mode_nxt[i] = mode_r[i];
      dl_nxt[i]   = dl_r[i];
    end
    if (cmd.load) begin
      exp_nxt = 1'b0;
    end else if (cmd.exec) begin
      case (cmd_r)
        ptb_pkg::CMD_TICK: begin
          if (sel_mode == ptb_pkg::MODE_STOPPED && time_inc[TW-1]) begin
            time_nxt = '0;
            for (int i = 0; i < BANK; i++) begin
              mode_nxt[i] = ptb_pkg::MODE_RUNNING;
              dl_nxt[i]   = '0;
            end
          end else begin
            time_nxt = time_inc;
          end
        end
        ptb_pkg::CMD_CHECK: begin
          if (sel_mode == ptb_pkg::MODE_STOPPED) begin
            exp_nxt = 1'b1;
          end else if (sel_mode == ptb_pkg::MODE_RUNNING && time_r >= dl_sel) begin
            mode_nxt[id_r[IDX_W-1:0]] = ptb_pkg::MODE_STOPPED;
            exp_nxt = 1'b1;
          end
        end
        ptb_pkg::CMD_START: begin
          if (id_ok) begin
            mode_nxt[id_r[IDX_W-1:0]] = ptb_pkg::MODE_RUNNING;
            dl_nxt[id_r[IDX_W-1:0]]   = quo_r + time_r;
          end
        end
        ptb_pkg::CMD_STOP: begin
          if (id_ok) begin
            mode_nxt[id_r[IDX_W-1:0]] = ptb_pkg::MODE_STOPPED;
            dl_nxt[id_r[IDX_W-1:0]]   = '0;
          end
        end
        ptb_pkg::CMD_PAUSE: begin
          if (sel_mode == ptb_pkg::MODE_RUNNING) begin
            mode_nxt[id_r[IDX_W-1:0]] = ptb_pkg::MODE_PAUSED;
            dl_nxt[id_r[IDX_W-1:0]]   = dl_sel - time_r;
          end
        end
        ptb_pkg::CMD_RELEASE: begin
          if (sel_mode == ptb_pkg::MODE_PAUSED) begin
            mode_nxt[id_r[IDX_W-1:0]] = ptb_pkg::MODE_RUNNING;
            dl_nxt[id_r[IDX_W-1:0]]   = dl_sel + time_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (sel_mode)
      ptb_pkg::MODE_PAUSED:  remaining = dl_sel;
      ptb_pkg::MODE_RUNNING: remaining = ((dl_sel - ptb_pkg::GUARD_TICKS) > time_r) ?
                                         (dl_sel - time_r) : '0;
      default:               remaining = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_id_r    <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BANK; i++) begin
        mode_r[i] <= ptb_pkg::MODE_STOPPED;
        dl_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        run_id_r <= cfg_wdata;
      end
      time_r <= time_nxt;
      for (int i = 0; i < BANK; i++) begin
        mode_r[i] <= mode_nxt[i];
        dl_r[i]   <= dl_nxt[i];
      end
      if (cmd.result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    if (cmd.load) begin
      cmd_r <= in_command;
      id_r  <= in_timer_id;
      quo_r <= in_delay_ms;
      cnt_r <= 1'b0;
    end else if (cmd.div_step) begin
      if (!cnt_r) begin
        mul_hi_r <= mul_full[2*TW-1:TW];
      end else begin
        quo_r <= quo_fix;
      end
      cnt_r <= 1'b1;
    end
    if (cmd.result) begin
      out_expired_r   <= exp_r;
      out_remaining_r <= remaining;
    end
  end

  assign sts.in_is_start = (in_command == ptb_pkg::CMD_START);
  assign sts.div_last    = cnt_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_expired         = out_expired_r;
  assign out_remaining_ticks = out_remaining_r;

endmodule

// File: test/tb_pausable_timer_bank_core.sv
module tb_pausable_timer_bank_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W = ptb_pkg::CMD_W;
  localparam int ID_W = ptb_pkg::ID_W;
  localparam int TIME_W = ptb_pkg::TIME_W;
  localparam int NUM_TIMERS = 8;
  localparam int TICK_PERIOD = 10;
  localparam logic [TIME_W-1:0] TICK_DIV = TICK_PERIOD;
  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              expired;
    logic [TIME_W-1:0] remaining;
  } timer_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ID_W-1:0] cfg_wdata;

  ptb_in_if  in_ch();
  ptb_out_if out_ch();

  pausable_timer_bank_core #(
    .NUM_TIMERS     (NUM_TIMERS),
    .TICK_PERIOD_MS (TICK_PERIOD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [TIME_W-1:0] sys_time;
  logic [ID_W-1:0]   run_id;
  ptb_pkg::mode_t    timer_mode [NUM_TIMERS];
  logic [TIME_W-1:0] deadline [NUM_TIMERS];

  timer_report_t pending_reports[$];
  int items_sent;
  int failures;
  bit quiet;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 400);
    if (r < 85) return $urandom_range(0, 20);
    if (r < 95) return $urandom();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd9;
      2: return 32'd10;
      3: return 32'hFFFF_FFF6;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic timer_report_t apply_timer_command(logic [CMD_W-1:0] cmd,
                                                        logic [ID_W-1:0] id,
                                                        logic [TIME_W-1:0] delay);
    timer_report_t rep;
    logic [TIME_W-1:0] guard_edge;
    rep.expired = 1'b0;
    case (cmd)
      ptb_pkg::CMD_TICK: begin
        sys_time = sys_time + 1'b1;
        if (timer_mode[run_id] == ptb_pkg::MODE_STOPPED && sys_time > HALF_RANGE) begin
          sys_time = '0;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            timer_mode[i] = ptb_pkg::MODE_RUNNING;
            deadline[i] = '0;
          end
        end
      end
      ptb_pkg::CMD_START: begin
        timer_mode[id] = ptb_pkg::MODE_RUNNING;
        deadline[id] = delay / TICK_DIV + sys_time;
      end
      ptb_pkg::CMD_STOP: begin
        timer_mode[id] = ptb_pkg::MODE_STOPPED;
        deadline[id] = '0;
      end
      ptb_pkg::CMD_PAUSE: begin
        if (timer_mode[id] == ptb_pkg::MODE_RUNNING) begin
          timer_mode[id] = ptb_pkg::MODE_PAUSED;
          deadline[id] = deadline[id] - sys_time;
        end
      end
      ptb_pkg::CMD_RELEASE: begin
        if (timer_mode[id] == ptb_pkg::MODE_PAUSED) begin
          timer_mode[id] = ptb_pkg::MODE_RUNNING;
          deadline[id] = deadline[id] + sys_time;
        end
      end
      ptb_pkg::CMD_CHECK: begin
        if (timer_mode[id] == ptb_pkg::MODE_STOPPED) begin
          rep.expired = 1'b1;
        end else if (timer_mode[id] == ptb_pkg::MODE_RUNNING &&
                     sys_time >= deadline[id]) begin
          timer_mode[id] = ptb_pkg::MODE_STOPPED;
          rep.expired = 1'b1;
        end
      end
      default: ;
    endcase
    guard_edge = deadline[id] - ptb_pkg::GUARD_TICKS;
    case (timer_mode[id])
      ptb_pkg::MODE_PAUSED: rep.remaining = deadline[id];
      ptb_pkg::MODE_RUNNING:
        rep.remaining = (guard_edge > sys_time) ? deadline[id] - sys_time : '0;
      default: rep.remaining = '0;
    endcase
    return rep;
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] delay);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.timer_id = id;
    in_ch.delay_ms = delay;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_reports.push_back(apply_timer_command(cmd, id, delay));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_run_timer(logic [ID_W-1:0] value);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    run_id = value;
  endtask

  task automatic test_directed();
    send_item(ptb_pkg::CMD_START, 3'd0, 32'd0);
    send_item(ptb_pkg::CMD_CHECK, 3'd0, 32'd0);
    send_item(ptb_pkg::CMD_START, 3'd7, 32'hFFFF_FFFF);
    send_item(ptb_pkg::CMD_CHECK, 3'd7, 32'd0);
    send_item(ptb_pkg::CMD_PAUSE, 3'd7, 32'd0);
    send_item(ptb_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF);
    send_item(ptb_pkg::CMD_RELEASE, 3'd7, 32'd0);
    send_item(ptb_pkg::CMD_STOP, 3'd7, 32'd0);
    send_item(ptb_pkg::CMD_CHECK, 3'd7, 32'd0);
    // deadlines just past the guard band
    send_item(ptb_pkg::CMD_START, 3'd1, 32'd19);
    send_item(ptb_pkg::CMD_START, 3'd2, 32'd35);
    send_item(ptb_pkg::CMD_PAUSE, 3'd3, 32'd0);
    send_item(ptb_pkg::CMD_RELEASE, 3'd4, 32'd0);
    send_item(ptb_pkg::CMD_RELEASE, 3'd1, 32'd0);
    send_item(ptb_pkg::CMD_TICK, 3'd0, 32'd0);
    send_item(ptb_pkg::CMD_TICK, 3'd5, 32'd0);
    send_item(ptb_pkg::CMD_TICK, 3'd2, 32'd0);
    send_item(ptb_pkg::CMD_CHECK, 3'd2, 32'd0);
    // pause past the deadline so the remainder wraps
    send_item(ptb_pkg::CMD_PAUSE, 3'd1, 32'd0);
    send_item(ptb_pkg::CMD_CHECK, 3'd1, 32'd0);
    send_item(ptb_pkg::CMD_TICK, 3'd1, 32'd0);
    send_item(ptb_pkg::CMD_RELEASE, 3'd1, 32'd0);
    send_item(CMD_SPARE_LO, 3'd1, 32'd0);
    send_item(CMD_SPARE_HI, 3'd7, 32'hFFFF_FFFF);
    send_item(ptb_pkg::CMD_START, 3'd6, 32'hFFFF_FFF6);
    send_item(ptb_pkg::CMD_CHECK, 3'd6, 32'd0);
  endtask

  task automatic send_noise_item();
    logic [CMD_W-1:0] cmd;
    if ($urandom_range(0, 99) < 5) begin
      cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
    end else begin
      cmd = CMD_W'($urandom_range(0, 5));
    end
    send_item(cmd, ID_W'($urandom_range(0, 7)), pick_delay());
  endtask

  task automatic test_lifecycles(int n);
    int target;
    int steps;
    int r;
    logic [ID_W-1:0] id;
    target = items_sent + n;
    while (items_sent < target) begin
      id = ID_W'($urandom_range(0, 7));
      send_item(ptb_pkg::CMD_START, id, pick_delay());
      steps = 0;
      while (timer_mode[id] != ptb_pkg::MODE_STOPPED && steps < 60 &&
             items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_item(ptb_pkg::CMD_TICK, ID_W'($urandom_range(0, 7)), $urandom());
        else if (r < 65) send_item(ptb_pkg::CMD_PAUSE, id, $urandom());
        else if (r < 75) send_item(ptb_pkg::CMD_RELEASE, id, $urandom());
        else if (r < 90) send_item(ptb_pkg::CMD_CHECK, id, $urandom());
        else if (r < 97) send_noise_item();
        else send_item(ptb_pkg::CMD_STOP, id, $urandom());
        steps++;
      end
    end
  endtask

  task automatic test_noise(int n);
    repeat (n) send_noise_item();
  endtask

  task automatic test_back_to_back(int n);
    quiet = 1'b1;
    test_lifecycles(n);
    quiet = 1'b0;
  endtask

  int stall_left;

  always @(negedge clk) begin
    if (quiet) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_ch.ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : score_results
    timer_report_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected result: expired %0b remaining %0d",
                   out_ch.expired, out_ch.remaining_ticks);
        end
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.expired !== want.expired || out_ch.remaining_ticks !== want.remaining) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("mismatch: expired exp %0b got %0b, remaining exp %0d got %0d",
                     want.expired, out_ch.expired, want.remaining, out_ch.remaining_ticks);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = ptb_pkg::CMD_TICK;
    in_ch.timer_id = '0;
    in_ch.delay_ms = '0;
    out_ch.ready = 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    items_sent = 0;
    failures = 0;
    sys_time = '0;
    run_id = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_mode[i] = ptb_pkg::MODE_STOPPED;
      deadline[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_run_timer(3'd0);
    test_directed();
    test_lifecycles(500);
    write_run_timer(3'd7);
    test_lifecycles(400);
    write_run_timer(ID_W'($urandom_range(0, 7)));
    test_noise(200);
    write_run_timer(3'd3);
    test_back_to_back(200);
    write_run_timer(3'd0);
    test_lifecycles(500);

    wait_drained();
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
